FILE: rtl/core/tms_pkg.sv
`default_nettype none

package tms_pkg;

   // Sizing of the machine.
   localparam int TAPE_DEPTH  = 1024;
   localparam int NUM_STATES  = 16;
   localparam int NUM_SYMBOLS = 16;

   localparam int TAPE_AW     = $clog2(TAPE_DEPTH);
   localparam int TABLE_DEPTH = NUM_STATES * NUM_SYMBOLS;
   localparam int TABLE_AW    = $clog2(TABLE_DEPTH);
   localparam int SYMBOL_W    = 4;
   localparam int ENTRY_W     = 11;

   localparam logic signed [11:0] HEAD_HOME = 12'(TAPE_DEPTH / 2);

   // Item kinds.
   localparam logic [1:0] KIND_LOAD  = 2'd0;
   localparam logic [1:0] KIND_TAPE  = 2'd1;
   localparam logic [1:0] KIND_START = 2'd2;
   localparam logic [1:0] KIND_STEP  = 2'd3;

   // Head moves.
   localparam logic [1:0] MOVE_NONE  = 2'd0;
   localparam logic [1:0] MOVE_RIGHT = 2'd1;
   localparam logic [1:0] MOVE_LEFT  = 2'd2;

   // Result status codes.
   localparam logic [2:0] ST_STEP   = 3'd0;
   localparam logic [2:0] ST_FINAL  = 3'd1;
   localparam logic [2:0] ST_ERROR  = 3'd2;
   localparam logic [2:0] ST_OFF    = 3'd3;
   localparam logic [2:0] ST_HALTED = 3'd4;
   localparam logic [2:0] ST_LIMIT  = 3'd5;
   localparam logic [2:0] ST_ACK    = 3'd6;

   // Register port.
   localparam int CSR_ADDR_W  = 3;
   localparam int CSR_DATA_W  = 32;
   localparam int CSR_IDX_LSB = 2;
   localparam logic CSR_IDX_FINAL = 1'b0;
   localparam logic CSR_IDX_MAX   = 1'b1;

   localparam logic [3:0]  FINAL_STATE_RESET = 4'd15;
   localparam logic [15:0] MAX_STEPS_RESET   = 16'd1000;

   typedef struct packed {
      logic [1:0] kind;
      logic [3:0] table_state;
      logic [3:0] table_symbol;
      logic [3:0] next_state;
      logic [3:0] write_symbol;
      logic [1:0] move_code;
      logic       is_error;
      logic [9:0] cell_address;
   } req_item_type;

   typedef struct packed {
      logic [2:0]         status;
      logic [3:0]         old_state;
      logic [3:0]         read_symbol;
      logic [3:0]         new_state;
      logic [3:0]         written_symbol;
      logic [1:0]         head_move;
      logic signed [11:0] head_position;
      logic [15:0]        steps_done;
   } rsp_item_type;

   typedef struct packed {
      logic       is_error;
      logic [1:0] move_code;
      logic [3:0] write_symbol;
      logic [3:0] next_state;
   } entry_type;

   typedef struct packed {
      logic [3:0]  final_state;
      logic [15:0] max_steps;
   } csr_cfg_type;

   typedef struct packed {
      logic clear_en;
      logic capture;
      logic tape_rd_en;
      logic table_rd_en;
      logic exec;
   } ctrl_cmd_type;

   typedef struct packed {
      logic clear_done;
      logic in_is_step;
      logic rsp_free;
   } dp_status_type;

endpackage

`default_nettype wire

FILE: rtl/core/tms_ram.sv
`default_nettype none

module tms_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

FILE: rtl/core/tms_csr.sv
`default_nettype none

module tms_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [tms_pkg::CSR_ADDR_W-1:0]      paddr,
   input  logic [tms_pkg::CSR_DATA_W-1:0]      pwdata,
   output logic [tms_pkg::CSR_DATA_W-1:0]      prdata,
   output logic                                pready,
   output tms_pkg::csr_cfg_type                cfg
);
   import tms_pkg::*;

   csr_cfg_type cfg_ff;
   csr_cfg_type cfg_in;
   logic        wr_strobe;
   logic        reg_idx;

   assign pready    = 1'b1;
   assign wr_strobe = psel && penable && pwrite && pready;
   assign reg_idx   = paddr[CSR_IDX_LSB];

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_strobe) begin
         case (reg_idx)
            CSR_IDX_FINAL: cfg_in.final_state = pwdata[3:0];
            CSR_IDX_MAX:   cfg_in.max_steps   = pwdata[15:0];
            default:       cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.final_state <= FINAL_STATE_RESET;
         cfg_ff.max_steps   <= MAX_STEPS_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      case (reg_idx)
         CSR_IDX_FINAL: prdata = CSR_DATA_W'(cfg_ff.final_state);
         CSR_IDX_MAX:   prdata = CSR_DATA_W'(cfg_ff.max_steps);
         default:       prdata = '0;
      endcase
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

FILE: rtl/core/tms_ctrl.sv
`default_nettype none

module tms_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  tms_pkg::dp_status_type status,
   output tms_pkg::ctrl_cmd_type  cmd
);
   import tms_pkg::*;

   localparam logic [1:0] S_CLEAR  = 2'd0;
   localparam logic [1:0] S_IDLE   = 2'd1;
   localparam logic [1:0] S_LOOKUP = 2'd2;
   localparam logic [1:0] S_EXEC   = 2'd3;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_CLEAR: begin
            cmd.clear_en = 1'b1;
            if (status.clear_done) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            // The tape is read under the head on every idle cycle, so the
            // cell is ready in the cycle after a step transaction is taken.
            cmd.tape_rd_en = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = status.in_is_step ? S_LOOKUP : S_EXEC;
            end
         end
         S_LOOKUP: begin
            cmd.table_rd_en = 1'b1;
            state_in        = S_EXEC;
         end
         S_EXEC: begin
            if (status.rsp_free) begin
               cmd.exec = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_stall = (state_ff != S_IDLE);

   // A step transaction always goes through the table lookup before it executes.
   assert property (@(posedge clock) disable iff (reset)
      (cmd.capture && status.in_is_step) |=> (state_ff == S_LOOKUP))
      else $error("step transaction skipped the table lookup");

   // Nothing is taken while the tape is still being cleared.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CLEAR) |-> (!cmd.capture && !cmd.exec))
      else $error("transaction handled during the clearing pass");

endmodule

`default_nettype wire

FILE: rtl/core/tms_datapath.sv
`default_nettype none

module tms_datapath (
   input  logic                   clock,
   input  logic                   reset,
   input  tms_pkg::ctrl_cmd_type  cmd,
   output tms_pkg::dp_status_type status,
   input  tms_pkg::csr_cfg_type   cfg,
   input  tms_pkg::req_item_type  req_item,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output tms_pkg::rsp_item_type  rsp_item
);
   import tms_pkg::*;

   req_item_type       item_ff, item_in;
   logic signed [11:0] head_ff, head_in;
   logic [3:0]         state_ff, state_in;
   logic               halted_ff, halted_in;
   logic [15:0]        count_ff, count_in;
   logic [TAPE_AW-1:0] clear_cnt_ff, clear_cnt_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_item_type       rsp_item_ff, rsp_item_in;

   logic [SYMBOL_W-1:0] tape_q;
   logic [ENTRY_W-1:0]  table_q;
   entry_type           entry;

   logic                tape_we;
   logic [TAPE_AW-1:0]  tape_waddr;
   logic [SYMBOL_W-1:0] tape_wdata;
   logic                table_we;
   logic [TABLE_AW-1:0] table_waddr;
   logic [TABLE_AW-1:0] table_raddr;

   logic               off_tape, moved_off, load_ok, tape_ok, bad_read;
   logic [1:0]         eff_move;
   logic signed [11:0] moved_head;
   logic               step_wr;
   logic [2:0]         res_status;
   logic [3:0]         res_rd, res_wr;
   logic [1:0]         res_mv;

   tms_ram #(.WIDTH(SYMBOL_W), .DEPTH(TAPE_DEPTH)) u_tape (
      .clock   (clock),
      .wr_en   (tape_we),
      .wr_addr (tape_waddr),
      .wr_data (tape_wdata),
      .rd_en   (cmd.tape_rd_en),
      .rd_addr (head_ff[TAPE_AW-1:0]),
      .rd_data (tape_q)
   );

   tms_ram #(.WIDTH(ENTRY_W), .DEPTH(TABLE_DEPTH)) u_table (
      .clock   (clock),
      .wr_en   (table_we),
      .wr_addr (table_waddr),
      .wr_data ({item_ff.is_error, item_ff.move_code, item_ff.write_symbol,
                 item_ff.next_state}),
      .rd_en   (cmd.table_rd_en),
      .rd_addr (table_raddr),
      .rd_data (table_q)
   );

   assign entry    = entry_type'(table_q);
   assign off_tape = (int'(head_ff) < 0) || (int'(head_ff) >= TAPE_DEPTH);
   assign load_ok  = (int'(item_ff.table_state) < NUM_STATES)
                  && (int'(item_ff.table_symbol) < NUM_SYMBOLS);
   assign tape_ok  = int'(item_ff.cell_address) < TAPE_DEPTH;
   assign bad_read = (int'(tape_q) >= NUM_SYMBOLS) || (int'(state_ff) >= NUM_STATES);

   assign table_waddr = TABLE_AW'(int'(item_ff.table_state) * NUM_SYMBOLS
                                  + int'(item_ff.table_symbol));
   assign table_raddr = TABLE_AW'(int'(state_ff) * NUM_SYMBOLS + int'(tape_q));

   always_comb begin
      case (entry.move_code)
         MOVE_RIGHT: begin
            eff_move   = MOVE_RIGHT;
            moved_head = head_ff + 12'sd1;
         end
         MOVE_LEFT: begin
            eff_move   = MOVE_LEFT;
            moved_head = head_ff - 12'sd1;
         end
         default: begin
            eff_move   = MOVE_NONE;
            moved_head = head_ff;
         end
      endcase
   end

   assign moved_off = (int'(moved_head) < 0) || (int'(moved_head) >= TAPE_DEPTH);

   always_comb begin
      head_in    = head_ff;
      state_in   = state_ff;
      halted_in  = halted_ff;
      count_in   = count_ff;
      res_status = ST_ACK;
      res_rd     = '0;
      res_wr     = '0;
      res_mv     = MOVE_NONE;
      step_wr    = 1'b0;
      if (cmd.exec) begin
         case (item_ff.kind)
            KIND_START: begin
               head_in   = HEAD_HOME;
               state_in  = '0;
               halted_in = 1'b0;
               count_in  = '0;
            end
            KIND_STEP: begin
               if (halted_ff || off_tape) begin
                  halted_in  = 1'b1;
                  res_status = ST_HALTED;
               end else if (count_ff >= cfg.max_steps) begin
                  halted_in  = 1'b1;
                  res_status = ST_LIMIT;
               end else if (bad_read || entry.is_error) begin
                  halted_in  = 1'b1;
                  res_status = ST_ERROR;
                  res_rd     = tape_q;
                  res_wr     = tape_q;
               end else begin
                  step_wr    = 1'b1;
                  res_status = ST_STEP;
                  res_rd     = tape_q;
                  res_wr     = entry.write_symbol;
                  res_mv     = eff_move;
                  head_in    = moved_head;
                  if (int'(entry.next_state) < NUM_STATES) begin
                     state_in = entry.next_state;
                  end
                  if (count_ff != 16'hFFFF) begin
                     count_in = count_ff + 16'd1;
                  end
                  if (entry.next_state == cfg.final_state) begin
                     res_status = ST_FINAL;
                     halted_in  = 1'b1;
                  end else if (moved_off) begin
                     res_status = ST_OFF;
                     halted_in  = 1'b1;
                  end
               end
            end
            default: ;
         endcase
      end
   end

   always_comb begin
      tape_we = cmd.clear_en
             || (cmd.exec && (((item_ff.kind == KIND_TAPE) && tape_ok) || step_wr));
      if (cmd.clear_en) begin
         tape_waddr = clear_cnt_ff;
         tape_wdata = '0;
      end else if (item_ff.kind == KIND_TAPE) begin
         tape_waddr = TAPE_AW'(item_ff.cell_address);
         tape_wdata = item_ff.write_symbol;
      end else begin
         tape_waddr = head_ff[TAPE_AW-1:0];
         tape_wdata = entry.write_symbol;
      end
   end

   assign table_we = cmd.exec && (item_ff.kind == KIND_LOAD) && load_ok;

   always_comb begin
      item_in      = cmd.capture ? req_item : item_ff;
      clear_cnt_in = cmd.clear_en ? clear_cnt_ff + TAPE_AW'(1) : clear_cnt_ff;
      rsp_item_in  = rsp_item_ff;
      rsp_valid_in = rsp_valid_ff;
      if (cmd.exec) begin
         rsp_item_in.status         = res_status;
         rsp_item_in.old_state      = (item_ff.kind == KIND_STEP) ? state_ff : state_in;
         rsp_item_in.read_symbol    = res_rd;
         rsp_item_in.new_state      = state_in;
         rsp_item_in.written_symbol = res_wr;
         rsp_item_in.head_move      = res_mv;
         rsp_item_in.head_position  = head_in;
         rsp_item_in.steps_done     = count_in;
         rsp_valid_in               = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      item_ff     <= item_in;
      rsp_item_ff <= rsp_item_in;
      if (reset) begin
         head_ff      <= HEAD_HOME;
         state_ff     <= '0;
         halted_ff    <= 1'b0;
         count_ff     <= '0;
         clear_cnt_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         head_ff      <= head_in;
         state_ff     <= state_in;
         halted_ff    <= halted_in;
         count_ff     <= count_in;
         clear_cnt_ff <= clear_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign status.clear_done = cmd.clear_en && (clear_cnt_ff == TAPE_AW'(TAPE_DEPTH - 1));
   assign status.in_is_step = (req_item.kind == KIND_STEP);
   assign status.rsp_free   = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

   // A finished result never overwrites one that has not been taken.
   assert property (@(posedge clock) disable iff (reset)
      cmd.exec |-> (!rsp_valid_ff || !rsp_stall))
      else $error("pending result overwritten");

   // Only a start transaction releases a halted machine.
   assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && $fell(halted_ff)) |-> $past(cmd.exec && (item_ff.kind == KIND_START)))
      else $error("machine left the halted state without a start");

   // A running machine always has its head on the tape.
   assert property (@(posedge clock) disable iff (reset)
      !halted_ff |-> !off_tape)
      else $error("head off the tape while the machine runs");

endmodule

`default_nettype wire

FILE: rtl/core/turing_machine_stepper.sv
`default_nettype none

// Single-tape Turing machine engine.
//
// Transactions arrive on the req_ channel (valid/stall) and each one gives
// exactly one result on the rsp_ channel. A load transaction fills one entry
// of the transition table, a tape transaction writes one tape cell, a start
// transaction homes the head to mid-tape and selects state 0, and a step
// transaction performs one transition and reports it.
// The final state and the step limit are set through the APB-style register
// port, which is always ready; registers should only be written while idle.
// A step transaction's result is registered after two dependent reads: the
// tape cell under the head is read at the accepting edge, the dependent table
// entry in the lookup state, and the cell is written back as the result is
// registered. Other transactions skip the lookup and are registered in the
// execute state. The machine handles one transaction at a time, so it takes no
// new transaction before it is through with the last one. The result register
// lets the next transaction be accepted while a result still waits; when
// rsp_stall holds a second result back, the machine waits with it. After reset
// the tape is cleared one cell per cycle, a pass over all TAPE_DEPTH (1024)
// cells during which req_stall stays high.

module turing_machine_stepper (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  tms_pkg::req_item_type           req_item,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output tms_pkg::rsp_item_type           rsp_item,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [tms_pkg::CSR_ADDR_W-1:0]  paddr,
   input  logic [tms_pkg::CSR_DATA_W-1:0]  pwdata,
   output logic [tms_pkg::CSR_DATA_W-1:0]  prdata,
   output logic                            pready
);
   import tms_pkg::*;

   csr_cfg_type   cfg;
   ctrl_cmd_type  cmd;
   dp_status_type dp_status;

   // Register port: holds the final state and the step limit.
   tms_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // Sequencer: clearing pass, acceptance, lookup and execution.
   tms_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (dp_status),
      .cmd       (cmd)
   );

   // Tape and table memories, machine state and the result register.
   tms_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (dp_status),
      .cfg       (cfg),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_item  (rsp_item)
   );

endmodule

`default_nettype wire
